// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the RTL core file.
// Both macros assume a clock named clk; ASSERT_IMP also assumes an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only outside reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, also checked while in reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/spct_pkg.sv =====
// ----------------------------------------------------------------------------
// spct_pkg
// Types and constants shared by the shape pair collision test pipeline.
// ----------------------------------------------------------------------------
package spct_pkg;

  localparam int CoordBits  = 24;
  localparam int SizeBits   = CoordBits - 1;
  localparam int DblBits    = CoordBits + 1;
  localparam int ProdBits   = 2 * DblBits;
  localparam int RadSqBits  = 2 * CoordBits;
  localparam int SumBits    = ProdBits + 1;
  localparam int FilterBits = 32;
  localparam int GroupBits  = 16;

  localparam int CfgDataBits = 32;
  localparam int CfgAddrBits = 3;
  localparam int CfgIdxLsb   = 2;
  localparam int CfgIdxBits  = CfgAddrBits - CfgIdxLsb;

  localparam logic [CfgIdxBits-1:0] REG_FILTER_BYPASS = '0;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_POINT  = 2'd1,
    KIND_CIRCLE = 2'd2,
    KIND_RECT   = 2'd3
  } kind_t;

  // Pair class after ordering by kind
  typedef enum logic [2:0] {
    PAIR_OFF,
    PAIR_PP,
    PAIR_PC,
    PAIR_CC,
    PAIR_PR,
    PAIR_CR,
    PAIR_RR
  } pair_t;

  typedef struct packed {
    kind_t                        kind;
    logic signed [CoordBits-1:0]  x;
    logic signed [CoordBits-1:0]  y;
    logic [SizeBits-1:0]          w;
    logic [SizeBits-1:0]          h;
    logic [FilterBits-1:0]        filt;
  } shape_t;

  typedef struct packed {
    logic  valid;
    pair_t pair;
    logic  filt;
  } ctrl_t;

  typedef struct packed {
    ctrl_t                ctrl;
    logic [CoordBits-1:0] dx;
    logic [CoordBits-1:0] dy;
    logic [CoordBits-1:0] size_x;
    logic [CoordBits-1:0] size_y;
    logic [CoordBits-1:0] radius;
  } prep_t;

  typedef struct packed {
    ctrl_t                ctrl;
    logic                 same_pos;
    logic                 in_box;
    logic [DblBits-1:0]   mx;
    logic [DblBits-1:0]   my;
    logic [CoordBits-1:0] mr;
  } clamp_t;

  typedef struct packed {
    ctrl_t                ctrl;
    logic                 same_pos;
    logic                 in_box;
    logic [ProdBits-1:0]  px;
    logic [ProdBits-1:0]  py;
    logic [RadSqBits-1:0] pr;
  } square_t;

endpackage

// ===== rtl/spct_prep.sv =====
// ----------------------------------------------------------------------------
// spct_prep
// Stage 1: pair classification, filter check, axis distances and sizes.
// ----------------------------------------------------------------------------
module spct_prep import spct_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  shape_t shape_a,
  input  shape_t shape_b,
  input  logic   bypass,
  output prep_t  prep_r
);

  shape_t                p;
  shape_t                q;
  pair_t                 pair;
  logic [CoordBits-1:0]  size_x;
  logic [CoordBits-1:0]  size_y;
  logic [CoordBits-1:0]  radius;
  logic [CoordBits:0]    dx_s;
  logic [CoordBits:0]    dy_s;
  logic [CoordBits-1:0]  dx_abs;
  logic [CoordBits-1:0]  dy_abs;
  logic                  group_hit;
  logic                  mask_miss;
  logic                  rejected;
  logic [CoordBits-1:0]  w_sum;
  logic [CoordBits-1:0]  h_sum;

  assign p = (shape_a.kind > shape_b.kind) ? shape_b : shape_a;
  assign q = (shape_a.kind > shape_b.kind) ? shape_a : shape_b;

  assign w_sum = CoordBits'(p.w) + CoordBits'(q.w);
  assign h_sum = CoordBits'(p.h) + CoordBits'(q.h);

  always_comb begin
    size_x = CoordBits'(q.w);
    size_y = CoordBits'(q.h);
    radius = '0;
    if (p.kind == KIND_NONE) begin
      pair = PAIR_OFF;
    end else if (q.kind == KIND_POINT) begin
      pair = PAIR_PP;
    end else if (q.kind == KIND_CIRCLE) begin
      if (p.kind == KIND_POINT) begin
        pair   = PAIR_PC;
        radius = CoordBits'(q.w);
      end else begin
        pair   = PAIR_CC;
        radius = w_sum;
      end
    end else if (p.kind == KIND_POINT) begin
      pair = PAIR_PR;
    end else if (p.kind == KIND_CIRCLE) begin
      // circle vs box is done in doubled units
      pair   = PAIR_CR;
      radius = {p.w, 1'b0};
    end else begin
      pair   = PAIR_RR;
      size_x = w_sum;
      size_y = h_sum;
    end
  end

  assign dx_s   = {shape_a.x[CoordBits-1], shape_a.x} - {shape_b.x[CoordBits-1], shape_b.x};
  assign dy_s   = {shape_a.y[CoordBits-1], shape_a.y} - {shape_b.y[CoordBits-1], shape_b.y};
  assign dx_abs = dx_s[CoordBits] ? CoordBits'(-dx_s) : dx_s[CoordBits-1:0];
  assign dy_abs = dy_s[CoordBits] ? CoordBits'(-dy_s) : dy_s[CoordBits-1:0];

  assign group_hit = (shape_a.filt[FilterBits-1:GroupBits] != '0) &&
                     (shape_b.filt[FilterBits-1:GroupBits] != '0) &&
                     (shape_a.filt[FilterBits-1:GroupBits] ==
                      shape_b.filt[FilterBits-1:GroupBits]);
  assign mask_miss = (shape_a.filt[GroupBits-1:0] != '0) &&
                     (shape_b.filt[GroupBits-1:0] != '0) &&
                     ((shape_a.filt[GroupBits-1:0] & shape_b.filt[GroupBits-1:0]) == '0);
  assign rejected  = !bypass && (group_hit || mask_miss);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.ctrl.valid <= 1'b0;
    end else begin
      prep_r.ctrl.valid <= in_valid;
    end
    prep_r.ctrl.pair <= pair;
    prep_r.ctrl.filt <= rejected;
    prep_r.dx        <= dx_abs;
    prep_r.dy        <= dy_abs;
    prep_r.size_x    <= size_x;
    prep_r.size_y    <= size_y;
    prep_r.radius    <= radius;
  end

endmodule

// ===== rtl/spct_clamp.sv =====
// ----------------------------------------------------------------------------
// spct_clamp
// Stage 2: box containment and distance from a circle center to the box.
// ----------------------------------------------------------------------------
module spct_clamp import spct_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  prep_t  prep,
  output clamp_t clamp_r
);

  logic [DblBits-1:0] dx2;
  logic [DblBits-1:0] dy2;
  logic [DblBits-1:0] sx;
  logic [DblBits-1:0] sy;
  logic               over_x;
  logic               over_y;
  logic [DblBits-1:0] ex;
  logic [DblBits-1:0] ey;

  assign dx2    = {prep.dx, 1'b0};
  assign dy2    = {prep.dy, 1'b0};
  assign sx     = DblBits'(prep.size_x);
  assign sy     = DblBits'(prep.size_y);
  assign over_x = dx2 > sx;
  assign over_y = dy2 > sy;
  assign ex     = over_x ? dx2 - sx : '0;
  assign ey     = over_y ? dy2 - sy : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_r.ctrl.valid <= 1'b0;
    end else begin
      clamp_r.ctrl.valid <= prep.ctrl.valid;
    end
    clamp_r.ctrl.pair <= prep.ctrl.pair;
    clamp_r.ctrl.filt <= prep.ctrl.filt;
    clamp_r.same_pos  <= (prep.dx == '0) && (prep.dy == '0);
    clamp_r.in_box    <= !over_x && !over_y;
    clamp_r.mx        <= (prep.ctrl.pair == PAIR_CR) ? ex : DblBits'(prep.dx);
    clamp_r.my        <= (prep.ctrl.pair == PAIR_CR) ? ey : DblBits'(prep.dy);
    clamp_r.mr        <= prep.radius;
  end

endmodule

// ===== rtl/spct_square.sv =====
// ----------------------------------------------------------------------------
// spct_square
// Stage 3: squares of the two axis distances and of the radius term.
// ----------------------------------------------------------------------------
module spct_square import spct_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  clamp_t  clamp,
  output square_t square_r
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_r.ctrl.valid <= 1'b0;
    end else begin
      square_r.ctrl.valid <= clamp.ctrl.valid;
    end
    square_r.ctrl.pair <= clamp.ctrl.pair;
    square_r.ctrl.filt <= clamp.ctrl.filt;
    square_r.same_pos  <= clamp.same_pos;
    square_r.in_box    <= clamp.in_box;
    square_r.px        <= ProdBits'(clamp.mx) * ProdBits'(clamp.mx);
    square_r.py        <= ProdBits'(clamp.my) * ProdBits'(clamp.my);
    square_r.pr        <= RadSqBits'(clamp.mr) * RadSqBits'(clamp.mr);
  end

endmodule

// ===== rtl/shape_pair_collision_test_core.sv =====
// ----------------------------------------------------------------------------
// shape_pair_collision_test_core
// Overlap test for one pair of shapes (point, circle, box) with group/mask
// filtering.
//
// Input: drive the two shapes on the in_* ports and raise start; the pair is
// taken at a clock edge where start is high and busy is low. busy is low at
// all times outside reset, so a new pair can be transferred every cycle.
// Output: out_strobe is high for one cycle with out_hit and out_filtered.
// After the transfer edge the pair passes the input register, then the
// distance, clamp, multiply and compare stages, one register each.
// Throughput is one pair per cycle; results leave in transfer order.
// The receiver has no back-pressure: every strobe must be taken.
// Config: one APB register at byte 0, bit 0 = filter bypass. Write only when
// no pair is in flight. pready is always high.
// Reset (synchronous, rst_n low): pipeline emptied, bypass cleared, busy high.
// ----------------------------------------------------------------------------
module shape_pair_collision_test_core import spct_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CfgAddrBits-1:0]      paddr,
  input  logic [CfgDataBits-1:0]      pwdata,
  output logic [CfgDataBits-1:0]      prdata,
  output logic                        pready,
  // command
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_first_kind,
  input  logic signed [CoordBits-1:0] in_first_x,
  input  logic signed [CoordBits-1:0] in_first_y,
  input  logic [SizeBits-1:0]         in_first_width,
  input  logic [SizeBits-1:0]         in_first_height,
  input  logic [FilterBits-1:0]       in_first_filter,
  input  logic [1:0]                  in_second_kind,
  input  logic signed [CoordBits-1:0] in_second_x,
  input  logic signed [CoordBits-1:0] in_second_y,
  input  logic [SizeBits-1:0]         in_second_width,
  input  logic [SizeBits-1:0]         in_second_height,
  input  logic [FilterBits-1:0]       in_second_filter,
  // result
  output logic                        out_strobe,
  output logic                        out_hit,
  output logic                        out_filtered
);

`include "assert_macros.svh"

  logic    filter_bypass_r;
  logic    cfg_wr;
  logic    accept;
  logic    in_valid_r;
  shape_t  first_r;
  shape_t  second_r;
  prep_t   prep;
  clamp_t  clamp;
  square_t square;

  logic [SumBits-1:0] dist_sq;
  logic [SumBits-1:0] rad_sq;
  logic               geom;
  logic               live;
  logic               out_strobe_r;
  logic               out_hit_r;
  logic               out_filtered_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CfgAddrBits-1:CfgIdxLsb] == REG_FILTER_BYPASS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_bypass_r <= 1'b0;
    end else if (cfg_wr) begin
      filter_bypass_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[CfgAddrBits-1:CfgIdxLsb] == REG_FILTER_BYPASS) begin
      prdata[0] = filter_bypass_r;
    end
  end

  // input register
  assign busy   = !rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r  <= '{kind: kind_t'(in_first_kind), x: in_first_x, y: in_first_y,
                    w: in_first_width, h: in_first_height, filt: in_first_filter};
      second_r <= '{kind: kind_t'(in_second_kind), x: in_second_x, y: in_second_y,
                    w: in_second_width, h: in_second_height, filt: in_second_filter};
    end
  end

  spct_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid_r),
    .shape_a  (first_r),
    .shape_b  (second_r),
    .bypass   (filter_bypass_r),
    .prep_r   (prep)
  );

  spct_clamp u_clamp (
    .clk     (clk),
    .rst_n   (rst_n),
    .prep    (prep),
    .clamp_r (clamp)
  );

  spct_square u_square (
    .clk      (clk),
    .rst_n    (rst_n),
    .clamp    (clamp),
    .square_r (square)
  );

  // final compare
  assign dist_sq = SumBits'(square.px) + SumBits'(square.py);
  assign rad_sq  = SumBits'(square.pr);

  always_comb begin
    unique case (square.ctrl.pair)
      PAIR_PP:          geom = square.same_pos;
      PAIR_PC, PAIR_CC: geom = dist_sq <= rad_sq;
      PAIR_CR:          geom = dist_sq < rad_sq;
      PAIR_PR, PAIR_RR: geom = square.in_box;
      default:          geom = 1'b0;
    endcase
  end

  assign live = square.ctrl.pair != PAIR_OFF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= square.ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r      <= live && !square.ctrl.filt && geom;
    out_filtered_r <= live && square.ctrl.filt;
  end

  assign out_strobe   = out_strobe_r;
  assign out_hit      = out_hit_r;
  assign out_filtered = out_filtered_r;

  `ASSERT_IMP(a_hit_excl_filt, out_strobe, !(out_hit && out_filtered))
  `ASSERT_IMP(a_latency, start && !busy, ##5 out_strobe)
  `ASSERT_IMP(a_bypass_no_filt, out_strobe && filter_bypass_r, !out_filtered)
  `ASSERT_NEXT(a_reset_quiet, !rst_n, !out_strobe)

endmodule

// ===== bench/tb_shape_pair_collision_test_core.sv =====
// ----------------------------------------------------------------------------
// tb_shape_pair_collision_test_core
// Self-checking bench for the shape pair overlap test. A directed table covers
// the kinds, the filter rules, coordinate and size extremes and the touching
// cases; random pairs follow, mostly clustered shapes so that boundaries are
// hit, with the filter bypass register toggled between phases and the sender
// idling at several rates. Results are checked by table or internal predictor.
// ----------------------------------------------------------------------------
module tb_shape_pair_collision_test_core;
  timeunit 1ns;
  timeprecision 1ps;

  import spct_pkg::*;

  typedef struct packed {
    logic hit;
    logic filtered;
  } verdict_t;

  typedef struct {
    shape_t   first;
    shape_t   second;
    logic     known;
    verdict_t want;
  } stim_row_t;

  localparam verdict_t NO_HIT   = '{hit: 1'b0, filtered: 1'b0};
  localparam verdict_t HIT      = '{hit: 1'b1, filtered: 1'b0};
  localparam verdict_t FILTERED = '{hit: 1'b0, filtered: 1'b1};

  localparam longint COORD_MIN = -(longint'(1) <<< (CoordBits - 1));
  localparam longint COORD_MAX = (longint'(1) <<< (CoordBits - 1)) - 1;
  localparam longint SIZE_MAX  = (longint'(1) <<< SizeBits) - 1;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_REPORTS     = 10;

  logic                        clk;
  logic                        rst_n            = 1'b0;
  logic                        psel             = 1'b0;
  logic                        penable          = 1'b0;
  logic                        pwrite           = 1'b0;
  logic [CfgAddrBits-1:0]      paddr            = '0;
  logic [CfgDataBits-1:0]      pwdata           = '0;
  logic [CfgDataBits-1:0]      prdata;
  logic                        pready;
  logic                        start            = 1'b0;
  logic                        busy;
  logic [1:0]                  in_first_kind    = '0;
  logic signed [CoordBits-1:0] in_first_x       = '0;
  logic signed [CoordBits-1:0] in_first_y       = '0;
  logic [SizeBits-1:0]         in_first_width   = '0;
  logic [SizeBits-1:0]         in_first_height  = '0;
  logic [FilterBits-1:0]       in_first_filter  = '0;
  logic [1:0]                  in_second_kind   = '0;
  logic signed [CoordBits-1:0] in_second_x      = '0;
  logic signed [CoordBits-1:0] in_second_y      = '0;
  logic [SizeBits-1:0]         in_second_width  = '0;
  logic [SizeBits-1:0]         in_second_height = '0;
  logic [FilterBits-1:0]       in_second_filter = '0;
  logic                        out_strobe;
  logic                        out_hit;
  logic                        out_filtered;

  verdict_t  pending_verdicts[$];
  logic      bypass_shadow = 1'b0;
  int        mismatch_count = 0;
  stim_row_t directed_rows[$];

  shape_pair_collision_test_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .in_first_kind    (in_first_kind),
    .in_first_x       (in_first_x),
    .in_first_y       (in_first_y),
    .in_first_width   (in_first_width),
    .in_first_height  (in_first_height),
    .in_first_filter  (in_first_filter),
    .in_second_kind   (in_second_kind),
    .in_second_x      (in_second_x),
    .in_second_y      (in_second_y),
    .in_second_width  (in_second_width),
    .in_second_height (in_second_height),
    .in_second_filter (in_second_filter),
    .out_strobe       (out_strobe),
    .out_hit          (out_hit),
    .out_filtered     (out_filtered)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** shape_pair_collision_test_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic filter_rejects(logic [FilterBits-1:0] f1,
                                          logic [FilterBits-1:0] f2);
    logic [GroupBits-1:0] g1, g2, m1, m2;
    g1 = f1[FilterBits-1:GroupBits];
    g2 = f2[FilterBits-1:GroupBits];
    m1 = f1[GroupBits-1:0];
    m2 = f2[GroupBits-1:0];
    if (g1 != '0 && g2 != '0 && g1 == g2) return 1'b1;
    return m1 != '0 && m2 != '0 && (m1 & m2) == '0;
  endfunction

  function automatic logic shapes_overlap(shape_t a, shape_t b);
    shape_t p, q;
    longint dx, dy, pw, ph, qw, qh, ex, ey;
    p = a;
    q = b;
    if (a.kind > b.kind) begin
      p = b;
      q = a;
    end
    dx = longint'($signed(p.x)) - longint'($signed(q.x));
    dy = longint'($signed(p.y)) - longint'($signed(q.y));
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    pw = longint'(p.w);
    ph = longint'(p.h);
    qw = longint'(q.w);
    qh = longint'(q.h);
    // half sizes appear in box tests, so those compare doubled distances
    if (p.kind == KIND_POINT && q.kind == KIND_POINT) return dx == 0 && dy == 0;
    if (p.kind == KIND_POINT && q.kind == KIND_CIRCLE) return dx*dx + dy*dy <= qw*qw;
    if (p.kind == KIND_CIRCLE && q.kind == KIND_CIRCLE)
      return dx*dx + dy*dy <= (pw + qw) * (pw + qw);
    if (p.kind == KIND_POINT && q.kind == KIND_RECT) return 2*dx <= qw && 2*dy <= qh;
    if (p.kind == KIND_CIRCLE && q.kind == KIND_RECT) begin
      ex = (2*dx > qw) ? 2*dx - qw : 0;
      ey = (2*dy > qh) ? 2*dy - qh : 0;
      return ex*ex + ey*ey < 4*pw*pw;
    end
    if (p.kind == KIND_RECT && q.kind == KIND_RECT)
      return 2*dx <= pw + qw && 2*dy <= ph + qh;
    return 1'b0;
  endfunction

  function automatic verdict_t judge_pair(shape_t a, shape_t b, logic bypass);
    verdict_t v;
    v = NO_HIT;
    if (a.kind == KIND_NONE || b.kind == KIND_NONE) return v;
    if (!bypass && filter_rejects(a.filt, b.filt)) return FILTERED;
    v.hit = shapes_overlap(a, b);
    return v;
  endfunction

  // ----------------------------------------------------------------- stimulus

  function automatic shape_t make_shape(kind_t k, longint x, longint y, longint w,
                                        longint h, logic [FilterBits-1:0] f);
    shape_t s;
    s.kind = k;
    s.x    = CoordBits'(x);
    s.y    = CoordBits'(y);
    s.w    = SizeBits'(w);
    s.h    = SizeBits'(h);
    s.filt = f;
    return s;
  endfunction

  function automatic kind_t random_kind();
    if ($urandom_range(0, 11) == 0) return KIND_NONE;
    return kind_t'($urandom_range(1, 3));
  endfunction

  function automatic logic [FilterBits-1:0] random_filter();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return $urandom;
      2: return {GroupBits'($urandom_range(0, 3)), GroupBits'(1 << $urandom_range(0, 15))};
      default: return {GroupBits'($urandom_range(0, 2)), GroupBits'($urandom_range(0, 7))};
    endcase
  endfunction

  function automatic longint edge_coord();
    case ($urandom_range(0, 3))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic longint edge_size();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 1;
      default: return SIZE_MAX;
    endcase
  endfunction

  task automatic random_pair(output shape_t a, output shape_t b);
    int     mode;
    longint scale;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      // clustered pair, scale spread so that small sizes hit the boundaries
      scale = longint'(1) <<< $urandom_range(0, 20);
      a = make_shape(random_kind(), $signed(CoordBits'($urandom)),
                     $signed(CoordBits'($urandom)), $urandom_range(0, int'(scale)),
                     $urandom_range(0, int'(scale)), random_filter());
      b = make_shape(random_kind(),
                     longint'($signed(a.x)) + $urandom_range(0, int'(4*scale)) - 2*scale,
                     longint'($signed(a.y)) + $urandom_range(0, int'(4*scale)) - 2*scale,
                     $urandom_range(0, int'(scale)), $urandom_range(0, int'(scale)),
                     random_filter());
    end else if (mode < 8) begin
      a = make_shape(random_kind(), $urandom, $urandom, $urandom, $urandom, $urandom);
      b = make_shape(random_kind(), $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      a = make_shape(random_kind(), edge_coord(), edge_coord(), edge_size(), edge_size(),
                     random_filter());
      b = make_shape(random_kind(), edge_coord(), edge_coord(), edge_size(), edge_size(),
                     random_filter());
    end
  endtask

  // Called in the step right after a rising edge; returns in the step of the
  // edge that completed the transfer, with start still high.
  task automatic send_pair(shape_t a, shape_t b, int idle_pct, logic known,
                           verdict_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start            <= 1'b1;
    in_first_kind    <= a.kind;
    in_first_x       <= a.x;
    in_first_y       <= a.y;
    in_first_width   <= a.w;
    in_first_height  <= a.h;
    in_first_filter  <= a.filt;
    in_second_kind   <= b.kind;
    in_second_x      <= b.x;
    in_second_y      <= b.y;
    in_second_width  <= b.w;
    in_second_height <= b.h;
    in_second_filter <= b.filt;
    do @(posedge clk); while (busy);
    pending_verdicts.push_back(known ? want : judge_pair(a, b, bypass_shadow));
  endtask

  task automatic wait_drained(int extra);
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // write the bypass register, then read it back
  task automatic set_bypass(logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrBits'(REG_FILTER_BYPASS) << CfgIdxLsb;
    pwdata  <= CfgDataBits'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    bypass_shadow = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CfgDataBits'(bypass_shadow))
      report_mismatch($sformatf("bypass readback expected %0h got %0h",
                                bypass_shadow, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ------------------------------------------------------------ result check

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_strobe) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no pair pending: hit %b filtered %b",
                                  out_hit, out_filtered));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_hit !== want.hit || out_filtered !== want.filtered)
          report_mismatch($sformatf("expected hit %b filtered %b, got hit %b filtered %b",
                                    want.hit, want.filtered, out_hit, out_filtered));
      end
    end
  end

  // -------------------------------------------------------------------- main

  initial begin
    int       phase_idle[PHASES];
    logic     phase_bypass[PHASES];
    shape_t   a, b;
    phase_idle   = '{0, 55, 0, 34, 55, 0};
    phase_bypass = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    directed_rows = '{
      // kind none short-circuits even a rejecting filter
      '{make_shape(KIND_NONE, 0, 0, 0, 0, 32'h0001_0000),
        make_shape(KIND_POINT, 0, 0, 0, 0, 32'h0001_0000), 1'b1, NO_HIT},
      '{make_shape(KIND_POINT, COORD_MAX, COORD_MIN, SIZE_MAX, SIZE_MAX, '1),
        make_shape(KIND_NONE, COORD_MAX, COORD_MIN, SIZE_MAX, SIZE_MAX, '1), 1'b1, NO_HIT},
      '{make_shape(KIND_POINT, COORD_MIN, COORD_MIN, 0, 0, '0),
        make_shape(KIND_POINT, COORD_MIN, COORD_MIN, 0, 0, '0), 1'b1, HIT},
      '{make_shape(KIND_POINT, COORD_MAX, COORD_MAX, 0, 0, '0),
        make_shape(KIND_POINT, COORD_MAX, COORD_MAX - 1, 0, 0, '0), 1'b1, NO_HIT},
      // same nonzero group
      '{make_shape(KIND_CIRCLE, 0, 0, 10, 0, 32'h0001_0000),
        make_shape(KIND_CIRCLE, 0, 0, 10, 0, 32'h0001_0000), 1'b1, FILTERED},
      // disjoint masks
      '{make_shape(KIND_POINT, 0, 0, 0, 0, 32'h0000_0001),
        make_shape(KIND_POINT, 0, 0, 0, 0, 32'h0000_0002), 1'b1, FILTERED},
      '{make_shape(KIND_POINT, 7, 7, 0, 0, 32'h0000_0003),
        make_shape(KIND_POINT, 7, 7, 0, 0, 32'h0000_0002), 1'b1, HIT},
      '{make_shape(KIND_POINT, 7, 7, 0, 0, 32'h0001_0000),
        make_shape(KIND_POINT, 7, 7, 0, 0, 32'h0002_0000), 1'b1, HIT},
      '{make_shape(KIND_RECT, 0, 0, 4, 4, '1),
        make_shape(KIND_RECT, 0, 0, 4, 4, '1), 1'b1, FILTERED},
      '{make_shape(KIND_POINT, 0, 0, 0, 0, 32'h0000_0000),
        make_shape(KIND_POINT, 0, 0, 0, 0, 32'h0000_0001), 1'b1, HIT},
      // point on the circle edge hits, outside misses
      '{make_shape(KIND_POINT, 0, 0, 0, 0, '0),
        make_shape(KIND_CIRCLE, 3, 4, 5, 0, '0), 1'b1, HIT},
      '{make_shape(KIND_POINT, 0, 0, 0, 0, '0),
        make_shape(KIND_CIRCLE, 3, 4, 4, 0, '0), 1'b1, NO_HIT},
      '{make_shape(KIND_CIRCLE, 0, 0, 2, 0, '0),
        make_shape(KIND_CIRCLE, 7, 0, 5, 0, '0), 1'b1, HIT},
      '{make_shape(KIND_CIRCLE, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, '0),
        make_shape(KIND_CIRCLE, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, '0), 1'b0, NO_HIT},
      // zero radius circle never hits a box, even at its centre
      '{make_shape(KIND_CIRCLE, 0, 0, 0, 0, '0),
        make_shape(KIND_RECT, 0, 0, 4, 4, '0), 1'b1, NO_HIT},
      '{make_shape(KIND_CIRCLE, 3, 0, 1, 0, '0),
        make_shape(KIND_RECT, 0, 0, 4, 4, '0), 1'b0, NO_HIT},
      '{make_shape(KIND_CIRCLE, 3, 0, 2, 0, '0),
        make_shape(KIND_RECT, 0, 0, 4, 4, '0), 1'b0, NO_HIT},
      '{make_shape(KIND_RECT, 0, 0, 4, 4, '0),
        make_shape(KIND_CIRCLE, 3, 0, 2, 0, '0), 1'b0, NO_HIT},
      '{make_shape(KIND_POINT, 2, 2, 0, 0, '0),
        make_shape(KIND_RECT, 0, 0, 4, 4, '0), 1'b1, HIT},
      // zero size box acts as a point
      '{make_shape(KIND_RECT, 5, 5, 0, 0, '0),
        make_shape(KIND_POINT, 5, 5, 0, 0, '0), 1'b1, HIT},
      '{make_shape(KIND_RECT, 0, 0, 4, 2, '0),
        make_shape(KIND_RECT, 4, 0, 4, 2, '0), 1'b0, NO_HIT},
      '{make_shape(KIND_RECT, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX, '0),
        make_shape(KIND_RECT, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX, '0), 1'b0, NO_HIT},
      '{make_shape(KIND_RECT, 0, 0, SIZE_MAX, SIZE_MAX, '0),
        make_shape(KIND_RECT, 0, 0, SIZE_MAX, SIZE_MAX, '0), 1'b1, HIT},
      '{make_shape(KIND_CIRCLE, 3, 4, 5, 0, '0),
        make_shape(KIND_POINT, 0, 0, 0, 0, '0), 1'b0, NO_HIT}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_bypass(1'b0);

    foreach (directed_rows[i])
      send_pair(directed_rows[i].first, directed_rows[i].second, 0,
                directed_rows[i].known, directed_rows[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained(DRAIN_CYCLES);
      set_bypass(phase_bypass[ph]);
      repeat (ITEMS_PER_PHASE) begin
        random_pair(a, b);
        send_pair(a, b, phase_idle[ph], 1'b0, NO_HIT);
      end
    end
    wait_drained(DRAIN_CYCLES);

    if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
      $display("** shape_pair_collision_test_core: PASSED **");
    end else begin
      $display("** shape_pair_collision_test_core: FAILED **");
    end
    $finish;
  end

endmodule
